// File: sv/nta_pkg.sv
// Shared types and constants of the neighbor table.
package nta_pkg;

  // Number of local interfaces that the subnet and own-address checks can use.
  localparam int unsigned NUM_IFACES = 2;
  // At most this many entries are returned by one list command.
  localparam int unsigned LIST_MAX   = 16;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned NAME_W  = 16;
  localparam int unsigned AGE_W   = 7;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned KCNT_W  = $clog2(LIST_MAX + 1);
  localparam int unsigned APB_AW  = 6;
  localparam int unsigned APB_DW  = 64;

  localparam logic [AGE_W-1:0] AGE_MAX      = '1;
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam logic [AGE_W-1:0] TIMEOUT_RST  = AGE_W'(30);

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_HELLO = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_LIST  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_LEARNED   = 3'd0,
    ST_REFRESHED = 3'd1,
    ST_OWN       = 3'd2,
    ST_OTHER_NET = 3'd3,
    ST_FULL      = 3'd4,
    ST_TICK      = 3'd5,
    ST_ENTRY     = 3'd6,
    ST_EMPTY     = 3'd7
  } status_e;

  // Configuration register indexes (byte address is eight times the index).
  typedef enum logic [2:0] {
    REG_IFACE0_MAC  = 3'd0,
    REG_IFACE0_IP   = 3'd1,
    REG_IFACE0_MASK = 3'd2,
    REG_IFACE1_MAC  = 3'd3,
    REG_IFACE1_IP   = 3'd4,
    REG_IFACE1_MASK = 3'd5,
    REG_IFACES_USED = 3'd6,
    REG_TIMEOUT     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [MAC_W-1:0]  iface0_mac;
    logic [IP_W-1:0]   iface0_ip;
    logic [IP_W-1:0]   iface0_mask;
    logic [MAC_W-1:0]  iface1_mac;
    logic [IP_W-1:0]   iface1_ip;
    logic [IP_W-1:0]   iface1_mask;
    logic [1:0]        ifaces_in_use;
    logic [AGE_W-1:0]  timeout_secs;
  } cfg_t;

  // One stored neighbor as held in the slot memory.
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [NAME_W-1:0] name;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic hello_cmp;
    logic hello_emit;
    logic tick_age;
    logic tick_shift;
    logic tick_emit;
    logic list_read;
    logic list_empty_emit;
    logic list_emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_emit;
    logic exp_empty;
    logic rem_empty;
    logic list_last;
  } dp_sts_t;

endpackage

// File: sv/nta_cfg.sv
// Configuration register file behind the APB port.
module nta_cfg import nta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q              <= '0;
      cfg_q.timeout_secs <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_IFACE0_MAC:  cfg_q.iface0_mac    <= pwdata[MAC_W-1:0];
        REG_IFACE0_IP:   cfg_q.iface0_ip     <= pwdata[IP_W-1:0];
        REG_IFACE0_MASK: cfg_q.iface0_mask   <= pwdata[IP_W-1:0];
        REG_IFACE1_MAC:  cfg_q.iface1_mac    <= pwdata[MAC_W-1:0];
        REG_IFACE1_IP:   cfg_q.iface1_ip     <= pwdata[IP_W-1:0];
        REG_IFACE1_MASK: cfg_q.iface1_mask   <= pwdata[IP_W-1:0];
        REG_IFACES_USED: cfg_q.ifaces_in_use <= pwdata[1:0];
        REG_TIMEOUT:     cfg_q.timeout_secs  <= pwdata[AGE_W-1:0];
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (idx)
      REG_IFACE0_MAC:  prdata = APB_DW'(cfg_q.iface0_mac);
      REG_IFACE0_IP:   prdata = APB_DW'(cfg_q.iface0_ip);
      REG_IFACE0_MASK: prdata = APB_DW'(cfg_q.iface0_mask);
      REG_IFACE1_MAC:  prdata = APB_DW'(cfg_q.iface1_mac);
      REG_IFACE1_IP:   prdata = APB_DW'(cfg_q.iface1_ip);
      REG_IFACE1_MASK: prdata = APB_DW'(cfg_q.iface1_mask);
      REG_IFACES_USED: prdata = APB_DW'(cfg_q.ifaces_in_use);
      REG_TIMEOUT:     prdata = APB_DW'(cfg_q.timeout_secs);
    endcase
  end

endmodule

// File: sv/nta_ctrl.sv
// Controller state machine that sequences hello, tick and list commands.
module nta_ctrl import nta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_stall_o,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HELLO_CMP,
    S_HELLO_DONE,
    S_TICK_AGE,
    S_TICK_CNT,
    S_LIST_FIND,
    S_LIST_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          unique case (cmd_e'(in_cmd_i))
            CMD_HELLO: state_d = S_HELLO_CMP;
            CMD_TICK:  state_d = S_TICK_AGE;
            CMD_LIST:  state_d = S_LIST_FIND;
            CMD_NONE:  state_d = S_IDLE;
          endcase
        end
      end
      S_HELLO_CMP: begin
        cmd_o.hello_cmp = 1'b1;
        state_d         = S_HELLO_DONE;
      end
      S_HELLO_DONE: begin
        if (sts_i.can_emit) begin
          cmd_o.hello_emit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_TICK_AGE: begin
        cmd_o.tick_age = 1'b1;
        state_d        = S_TICK_CNT;
      end
      S_TICK_CNT: begin
        if (!sts_i.exp_empty) begin
          cmd_o.tick_shift = 1'b1;
        end else if (sts_i.can_emit) begin
          cmd_o.tick_emit = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_LIST_FIND: begin
        // The slot set only runs dry here before the first entry went out.
        if (!sts_i.rem_empty) begin
          cmd_o.list_read = 1'b1;
          state_d         = S_LIST_OUT;
        end else if (sts_i.can_emit) begin
          cmd_o.list_empty_emit = 1'b1;
          state_d               = S_IDLE;
        end
      end
      S_LIST_OUT: begin
        if (sts_i.can_emit) begin
          cmd_o.list_emit = 1'b1;
          state_d         = sts_i.list_last ? S_IDLE : S_LIST_FIND;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  // Any accepted word with a real command keeps the input side stalled next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_cmd_i != CMD_NONE)) |=> in_stall_o)
    else $error("input not stalled after accepting a command");
`endif

endmodule

// File: sv/nta_dp.sv
// Datapath: slot rows, parallel MAC compare, aging, entry memory and output register.
module nta_dp import nta_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [1:0]        cmd_in_i,
  input  logic [MAC_W-1:0]  payload_mac_i,
  input  logic [IP_W-1:0]   payload_ip_i,
  input  logic [IP_W-1:0]   source_ip_i,
  input  logic [NAME_W-1:0] name_tag_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [MAC_W-1:0]  entry_mac_o,
  output logic [IP_W-1:0]   entry_ip_o,
  output logic [NAME_W-1:0] entry_name_o,
  output logic [CNT_W-1:0]  expired_count_o,
  output logic              last_o
);

  localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Captured input word.
  logic [1:0]         item_cmd_q;
  logic [MAC_W-1:0]   mac_q;
  logic [IP_W-1:0]    ip_q;
  logic [IP_W-1:0]    src_q;
  logic [NAME_W-1:0]  name_q;

  // Slot rows and entry memory.
  logic [CAPACITY-1:0] valid_q;
  logic [MAC_W-1:0]    mac_row_q [CAPACITY];
  logic [AGE_W-1:0]    age_q     [CAPACITY];
  entry_t              slot_mem  [CAPACITY];
  entry_t              rd_q;

  // Hello compare results.
  logic [CAPACITY-1:0] match_q;
  logic                own_q;
  logic                near_q;

  // Tick and list bookkeeping.
  logic [CAPACITY-1:0] exp_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CAPACITY-1:0] rem_q;
  logic [KCNT_W-1:0]   k_q;

  // Output register.
  logic               out_valid_q;
  status_e            st_q;
  entry_t             out_ent_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic               out_last_q;

  logic                used0, used1;
  logic                own_d, near_d;
  logic [CAPACITY-1:0] free_vec, free_oh;
  logic [SLOT_W-1:0]   free_idx, rem_idx;
  logic [AGE_W-1:0]    age_inc [CAPACITY];
  logic [CAPACITY-1:0] exp_vec;
  status_e             hello_st;
  logic                learn, refresh, emit_any;

  // Index of the lowest set bit of a slot vector.
  function automatic logic [SLOT_W-1:0] lowest_idx(input logic [CAPACITY-1:0] v);
    logic [CAPACITY-1:0] oh;
    logic [SLOT_W-1:0]   idx;
    oh  = v & (~v + 1'b1);
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (oh[i]) idx = idx | SLOT_W'(i);
    end
    return idx;
  endfunction

  // Interface checks against the captured hello.
  always_comb begin
    used0  = (cfg_i.ifaces_in_use >= 2'd1);
    used1  = (NUM_IFACES >= 2) && (cfg_i.ifaces_in_use >= 2'd2);
    own_d  = (used0 && (cfg_i.iface0_mac == mac_q)) ||
             (used1 && (cfg_i.iface1_mac == mac_q));
    near_d = (used0 && ((src_q & cfg_i.iface0_mask) ==
                        (cfg_i.iface0_ip & cfg_i.iface0_mask))) ||
             (used1 && ((src_q & cfg_i.iface1_mask) ==
                        (cfg_i.iface1_ip & cfg_i.iface1_mask)));
  end

  // Lowest free slot for a new neighbor.
  assign free_vec = ~valid_q;
  assign free_oh  = free_vec & (~free_vec + 1'b1);
  assign free_idx = lowest_idx(free_vec);
  assign rem_idx  = lowest_idx(rem_q);

  // Hello verdict from the registered compare.
  always_comb begin
    priority if (own_q)   hello_st = ST_OWN;
    else if (!near_q)     hello_st = ST_OTHER_NET;
    else if (|match_q)    hello_st = ST_REFRESHED;
    else if (|free_vec)   hello_st = ST_LEARNED;
    else                  hello_st = ST_FULL;
  end

  assign learn   = cmd_i.hello_emit && (hello_st == ST_LEARNED);
  assign refresh = cmd_i.hello_emit && (hello_st == ST_REFRESHED);

  // Aged values and expiry for every slot in parallel.
  always_comb begin
    for (int s = 0; s < CAPACITY; s++) begin
      age_inc[s] = (age_q[s] == AGE_MAX) ? age_q[s] : age_q[s] + 1'b1;
      exp_vec[s] = valid_q[s] && (age_inc[s] > cfg_i.timeout_secs);
    end
  end

  // Captured input word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_cmd_q <= cmd_in_i;
      mac_q      <= payload_mac_i;
      ip_q       <= payload_ip_i;
      src_q      <= source_ip_i;
      name_q     <= name_tag_i;
    end
  end

  // Slot valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.tick_age) begin
      valid_q <= valid_q & ~exp_vec;
    end else if (learn) begin
      valid_q <= valid_q | free_oh;
    end
  end

  // MAC and age rows.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < CAPACITY; s++) begin
      if (cmd_i.tick_age && valid_q[s]) begin
        age_q[s] <= age_inc[s];
      end else if ((refresh && match_q[s]) || (learn && free_oh[s])) begin
        age_q[s] <= '0;
      end
      if (learn && free_oh[s]) begin
        mac_row_q[s] <= mac_q;
      end
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (learn) begin
      slot_mem[free_idx] <= '{mac: mac_q, ip: ip_q, name: name_q};
    end
    if (cmd_i.list_read) begin
      rd_q <= slot_mem[rem_idx];
    end
  end

  // Parallel MAC compare and interface checks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      own_q   <= 1'b0;
      near_q  <= 1'b0;
    end else if (cmd_i.hello_cmp) begin
      for (int s = 0; s < CAPACITY; s++) begin
        match_q[s] <= valid_q[s] && (mac_row_q[s] == mac_q);
      end
      own_q  <= own_d;
      near_q <= near_d;
    end
  end

  // Expired-slot count, one slot bit shifted out per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.tick_age) begin
      exp_q <= exp_vec;
      cnt_q <= '0;
    end else if (cmd_i.tick_shift) begin
      exp_q <= exp_q >> 1;
      if (exp_q[0] && (cnt_q != CNT_MAX)) cnt_q <= cnt_q + 1'b1;
    end
  end

  // Slots still to list and entries listed so far.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      k_q   <= '0;
    end else if (cmd_i.load_item) begin
      rem_q <= valid_q;
      k_q   <= '0;
    end else if (cmd_i.list_read) begin
      rem_q <= rem_q & (rem_q - 1'b1);
      k_q   <= k_q + 1'b1;
    end
  end

  assign emit_any = cmd_i.hello_emit || cmd_i.tick_emit ||
                    cmd_i.list_empty_emit || cmd_i.list_emit;

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_any) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word.
  always_ff @(posedge clk_i) begin
    if (emit_any) begin
      out_ent_q  <= '0;
      out_cnt_q  <= '0;
      out_last_q <= 1'b1;
      priority if (cmd_i.hello_emit) begin
        st_q <= hello_st;
      end else if (cmd_i.tick_emit) begin
        st_q      <= ST_TICK;
        out_cnt_q <= cnt_q;
      end else if (cmd_i.list_empty_emit) begin
        st_q <= ST_EMPTY;
      end else begin
        st_q       <= ST_ENTRY;
        out_ent_q  <= rd_q;
        out_last_q <= sts_o.list_last;
      end
    end
  end

  assign sts_o.can_emit  = !out_valid_q || !out_stall_i;
  assign sts_o.exp_empty = (exp_q == '0);
  assign sts_o.rem_empty = (rem_q == '0);
  assign sts_o.list_last = (rem_q == '0) || (k_q == KCNT_W'(LIST_MAX));

  assign out_valid_o     = out_valid_q;
  assign status_o        = st_q;
  assign entry_mac_o     = out_ent_q.mac;
  assign entry_ip_o      = out_ent_q.ip;
  assign entry_name_o    = out_ent_q.name;
  assign expired_count_o = out_cnt_q;
  assign last_o          = out_last_q;

`ifndef ASSERT_OFF
  // Stored MACs are unique, so a hello hits at most one slot.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_q))
    else $error("hello matched more than one slot");

  // Only a tick result carries an expired count.
  a_count_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_TICK)) |-> (expired_count_o == '0))
    else $error("expired count on a non-tick result");

  // A list never issues more reads than its limit.
  a_list_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q <= KCNT_W'(LIST_MAX)))
    else $error("list read count above limit");

  // A learned hello marks its slot valid on the next cycle.
  a_learn_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    learn |=> ((valid_q & $past(free_oh)) != '0))
    else $error("learned slot not valid");
`endif

endmodule

// File: sv/neighbor_table_with_aging.sv
// Top level of the neighbor table with aging.
//
// Input words (cmd_i and payload) are taken when in_valid_i is high and in_stall_o
// low; one word is worked on at a time and in_stall_o stays high until it is done.
// A hello gives one result: the idle state takes the word, a compare state runs the
// parallel MAC compare over all slot rows, and a done state decides and loads the
// output register. A tick gives one result: all valid slots are aged in parallel,
// then the bits of the expired-slot vector are shifted out and counted one per
// cycle, up to the highest expired slot. A list gives one result per valid slot in
// slot order (at most 16), or one empty result; each entry is read through the
// registered read port of the entry memory before it goes to the output
// register. The last result of every word has last_o high. cmd 3 gives no result.
// Results sit in an output register; when out_stall_i holds it, the block waits in
// its emitting state, and a new word is taken once the current one has finished.
// Reset empties the table and sets the configuration registers to their defaults
// (timeout 30). Configuration is written over APB; pready is always high.
module neighbor_table_with_aging import nta_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [MAC_W-1:0]  payload_mac_i,
  input  logic [IP_W-1:0]   payload_ip_i,
  input  logic [IP_W-1:0]   source_ip_i,
  input  logic [NAME_W-1:0] name_tag_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [MAC_W-1:0]  entry_mac_o,
  output logic [IP_W-1:0]   entry_ip_o,
  output logic [NAME_W-1:0] entry_name_o,
  output logic [CNT_W-1:0]  expired_count_o,
  output logic              last_o
);

  cfg_t    cfg;
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  nta_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  nta_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .cmd_in_i        (cmd_i),
    .payload_mac_i   (payload_mac_i),
    .payload_ip_i    (payload_ip_i),
    .source_ip_i     (source_ip_i),
    .name_tag_i      (name_tag_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .entry_mac_o     (entry_mac_o),
    .entry_ip_o      (entry_ip_o),
    .entry_name_o    (entry_name_o),
    .expired_count_o (expired_count_o),
    .last_o          (last_o)
  );

endmodule
